@@ rtl/dlt_pkg.sv @@
`timescale 1ns / 1ps

package dlt_pkg;

	localparam int unsigned OFS_W = 16;

	localparam logic [31:0] MAX_LEN_DEFAULT = 32'd65535;
	localparam logic [7:0]  DELIM_RESET     = 8'd44;
	localparam logic [7:0]  QUOTE_CH        = 8'h22;
	localparam logic [7:0]  BACKSLASH_CH    = 8'h5C;
	localparam logic [7:0]  COMMA_CH        = 8'h2C;
	localparam logic [7:0]  SPACE_CH        = 8'h20;
	localparam logic [7:0]  TAB_CH          = 8'h09;
	localparam logic [7:0]  LF_CH           = 8'h0A;
	localparam logic [7:0]  CR_CH           = 8'h0D;

	typedef struct packed {
		logic [OFS_W-1:0] position;
		logic             in_item;
		logic             quoted;
		logic             escape_pending;
		logic [OFS_W-1:0] start_offset;
		logic [OFS_W-1:0] end_offset;
	} tok_state_t;

	typedef struct packed {
		logic             item_valid;
		logic [OFS_W-1:0] item_start;
		logic [OFS_W-1:0] item_length;
		logic             list_end;
		logic             open_quote;
	} tok_result_t;

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
	endfunction

	function automatic logic is_skip(input logic [7:0] c, input logic [7:0] delim);
		is_skip = (c == SPACE_CH) || (c == TAB_CH) || (c == CR_CH) || (c == LF_CH) ||
			(c == COMMA_CH) || (c == delim);
	endfunction

endpackage

@@ rtl/dlt_step.sv @@
`timescale 1ns / 1ps

module dlt_step #(
	parameter logic [31:0] MAX_LEN = dlt_pkg::MAX_LEN_DEFAULT
) (
	input  logic [7:0]          ch,
	input  logic                final_char,
	input  logic [7:0]          delimiter,
	input  dlt_pkg::tok_state_t cur,
	output dlt_pkg::tok_state_t nxt,
	output logic                emit,
	output dlt_pkg::tok_result_t res
);

	localparam logic [dlt_pkg::OFS_W-1:0] LIMIT =
		(MAX_LEN < 32'd65535) ? MAX_LEN[dlt_pkg::OFS_W-1:0] : {dlt_pkg::OFS_W{1'b1}};

	logic                      start_now;
	logic                      ii;
	logic                      q;
	logic                      e;
	logic                      ended;
	logic                      content;
	logic [dlt_pkg::OFS_W-1:0] p1;
	logic [dlt_pkg::OFS_W-1:0] so;
	logic [dlt_pkg::OFS_W-1:0] eo;
	logic [dlt_pkg::OFS_W-1:0] s;
	logic [dlt_pkg::OFS_W-1:0] len;

	always_comb begin
		p1        = (cur.position < LIMIT) ? cur.position + 1'b1 : LIMIT;
		start_now = !cur.in_item && !dlt_pkg::is_skip(ch, delimiter);
		ii        = cur.in_item || start_now;
		q         = start_now ? 1'b0 : cur.quoted;
		e         = start_now ? 1'b0 : cur.escape_pending;
		so        = start_now ? cur.position : cur.start_offset;
		eo        = start_now ? cur.position : cur.end_offset;
		ended     = 1'b0;
		content   = 1'b1;
		if (ii) begin
			if (e) begin
				e = 1'b0;
			end else if (q) begin
				if (((ch == dlt_pkg::QUOTE_CH) || (ch == dlt_pkg::BACKSLASH_CH)) &&
					(ch == delimiter)) begin
					ended   = 1'b1;
					content = 1'b0;
				end else if (ch == dlt_pkg::QUOTE_CH) begin
					q = 1'b0;
				end else if (ch == dlt_pkg::BACKSLASH_CH) begin
					e = 1'b1;
				end
			end else begin
				if (ch == delimiter) begin
					ended   = 1'b1;
					content = 1'b0;
				end else if (ch == dlt_pkg::QUOTE_CH) begin
					q = 1'b1;
				end
			end
			if (content && !dlt_pkg::is_ws(ch)) begin
				eo = p1;
			end
		end
		s   = ii ? so : '0;
		len = (ii && (eo > so)) ? eo - so : '0;

		res.item_valid  = (len != '0);
		res.item_start  = s;
		res.item_length = len;
		res.list_end    = final_char;
		res.open_quote  = final_char & q;

		nxt.position       = p1;
		nxt.in_item        = ii;
		nxt.quoted         = q;
		nxt.escape_pending = e;
		nxt.start_offset   = so;
		nxt.end_offset     = eo;
		emit               = 1'b0;

		if (final_char) begin
			emit = 1'b1;
			nxt  = '0;
		end else if (ended) begin
			nxt.in_item        = 1'b0;
			nxt.quoted         = 1'b0;
			nxt.escape_pending = 1'b0;
			emit               = (len != '0);
		end
	end

endmodule

@@ rtl/dlt_out_reg.sv @@
`timescale 1ns / 1ps

module dlt_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  dlt_pkg::tok_result_t res,
	input  logic                 out_ready,
	output logic                 out_valid,
	output dlt_pkg::tok_result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

@@ rtl/delimited_list_tokenizer_core.sv @@
`timescale 1ns / 1ps
// path: input register, then result register; out_valid rises only for a character that emits a result word
// throughput: one character per cycle while the result side keeps out_ready high
// the input register advances each cycle the result register is free, loading it only when a word is emitted
// reset: arst_n clears position, item and quote state, both valid flags, delimiter back to comma

module delimited_list_tokenizer_core #(
	parameter logic [31:0] MAX_LEN = dlt_pkg::MAX_LEN_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        final_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_valid,
	output logic [15:0] item_start,
	output logic [15:0] item_length,
	output logic        list_end,
	output logic        open_quote
);

	logic                 cfg_wr;
	logic [7:0]           delimiter_q;
	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 fin_s1;
	logic                 advance;
	logic                 emit;
	dlt_pkg::tok_state_t  state_q;
	dlt_pkg::tok_state_t  state_nxt;
	dlt_pkg::tok_result_t res;
	dlt_pkg::tok_result_t res_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= dlt_pkg::DELIM_RESET;
		end else if (cfg_wr) begin
			delimiter_q <= cfg_data;
		end
	end

	// input word register
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1  <= ch;
			fin_s1 <= final_char;
		end
	end

	dlt_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.ch        (ch_s1),
		.final_char(fin_s1),
		.delimiter (delimiter_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	dlt_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.res      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.res_q    (res_q)
	);

	assign item_valid  = res_q.item_valid;
	assign item_start  = res_q.item_start;
	assign item_length = res_q.item_length;
	assign list_end    = res_q.list_end;
	assign open_quote  = res_q.open_quote;

	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (item_valid == (item_length != 16'd0)))
		else $error("item_valid disagrees with item_length");

	a_mid_list: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !list_end) |-> (item_valid && !open_quote))
		else $error("mid-list word without an item");

	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin_s1) |=> (state_q.position == 16'd0 && !state_q.in_item &&
			!state_q.quoted))
		else $error("state not cleared after final character");

	a_escape: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape_pending |-> (state_q.quoted && state_q.in_item))
		else $error("escape pending outside a quoted item");

endmodule
